// ===== rtl/prt_pkg.sv =====
// Shared constants and types for the page region table.
`timescale 1ns / 1ps
`default_nettype none
package prt_pkg;

    localparam int ATTR_W = 4;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_FIND   = 2'd1;
    localparam logic [1:0] MODE_MAP    = 2'd2;
    localparam logic [1:0] MODE_UNMAP  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CFG_LOW  = 1'b0;
    localparam logic CFG_HIGH = 1'b1;

    // which pieces of an entry survive a cut
    typedef struct packed {
        logic keep_a;
        logic keep_b;
    } t_cut_flags;

endpackage
`default_nettype wire

// ===== rtl/page_region_table.sv =====
// Page region table top level: sequencer, ping-pong region banks and result register.
// Holds up to ENTRIES non-overlapping half-open page regions sorted by start page.
// One transaction is handled at a time; the input stalls until its result is registered.
// Each table entry a pass reaches is handled with a bank read, then an evaluate step,
// and a cut pass adds a write step per surviving piece it writes; a map at a searched
// page runs a search and then a cut pass. The cut pass streams the live bank into
// the spare bank; the banks swap only when the new table fits, so a full table
// leaves the old contents in place. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module page_region_table
    import prt_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int PAGE_BITS = 20
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // config
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire  [PAGE_BITS-1:0] i_cfg_data,
    // request
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  [1:0]           i_mode,
    input  wire  [PAGE_BITS-1:0] i_page,
    input  wire  [PAGE_BITS-1:0] i_page_count,
    input  wire                  i_search_downward,
    input  wire  [2:0]           i_access_bits,
    input  wire                  i_shared_map,
    input  wire  [PAGE_BITS-1:0] i_page_offset,
    // result
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic [1:0]           o_status,
    output logic [PAGE_BITS-1:0] o_start_page,
    output logic [PAGE_BITS-1:0] o_end_page,
    output logic [2:0]           o_region_access,
    output logic                 o_region_shared,
    output logic [PAGE_BITS-1:0] o_region_offset
);
    localparam int PB = PAGE_BITS;
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int NW = $clog2(ENTRIES + 3);
    localparam int EW = 3 * PB + ATTR_W;
    localparam logic [PB-1:0] PMAX = {PB{1'b1}};

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SRD  = 8'b0000_0010,   // scan: read entry
        S_SEV  = 8'b0000_0100,   // scan: lookup / gap step
        S_CRD  = 8'b0000_1000,   // cut: read entry
        S_CEV  = 8'b0001_0000,   // cut: split into pieces
        S_CWR  = 8'b0010_0000,   // cut: write pieces
        S_FIN  = 8'b0100_0000,   // cut: tail insert, fit check, swap
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [PB-1:0] r_user_low, r_user_high;

    logic [1:0]        r_mode, n_mode;
    logic [PB-1:0]     r_page, n_page;
    logic [PB-1:0]     r_cnt, n_cnt;
    logic              r_down, n_down;
    logic [ATTR_W-1:0] r_attr, n_attr;
    logic [PB-1:0]     r_off, n_off;
    logic [PB-1:0]     r_lo, n_lo;
    logic [PB-1:0]     r_hi, n_hi;
    logic [CW-1:0]     r_idx, n_idx;
    logic [NW-1:0]     r_n, n_n;
    logic              r_ins, n_ins;
    logic [PB-1:0]     r_cur, n_cur;
    logic              r_gok, n_gok;
    logic [PB-1:0]     r_gfound, n_gfound;
    logic [EW-1:0]     r_pa, n_pa, r_pb, n_pb;
    logic              r_pa_v, n_pa_v, r_pb_v, n_pb_v;
    logic              r_sel, n_sel;
    logic [CW-1:0]     r_count, n_count;

    logic [1:0]        r_st, n_st;
    logic [PB-1:0]     r_sp, n_sp, r_ep, n_ep, r_ro, n_ro;
    logic [ATTR_W-1:0] r_ra, n_ra;

    logic              r_ov;
    logic [1:0]        r_o_st;
    logic [PB-1:0]     r_o_sp, r_o_ep, r_o_ro;
    logic [ATTR_W-1:0] r_o_ra;

    // banks
    logic [EW-1:0] rd0, rd1, rd_data, wdata;
    logic          we;
    logic [IW-1:0] raddr;

    assign raddr   = r_idx[IW-1:0];
    assign rd_data = r_sel ? rd1 : rd0;

    prt_bank #(.DEPTH(ENTRIES), .EW(EW)) u_bank0 (
        .i_clk(i_clk), .i_we(we & r_sel), .i_waddr(r_n[IW-1:0]), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd0)
    );
    prt_bank #(.DEPTH(ENTRIES), .EW(EW)) u_bank1 (
        .i_clk(i_clk), .i_we(we & ~r_sel), .i_waddr(r_n[IW-1:0]), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd1)
    );

    // cut unit
    logic [EW-1:0] cut_a, cut_b;
    t_cut_flags    cut_f;

    prt_cut #(.PB(PB)) u_cut (
        .i_entry(rd_data), .i_lo(r_lo), .i_hi(r_hi),
        .o_a(cut_a), .o_b(cut_b), .o_flags(cut_f)
    );

    // fields of the entry just read
    logic [PB-1:0]     e_s, e_e, e_o;
    logic [ATTR_W-1:0] e_a;
    assign {e_a, e_o, e_e, e_s} = rd_data;

    logic [PB-1:0] pa_s;
    assign pa_s = r_pa[PB-1:0];

    logic [EW-1:0] new_ent;
    assign new_ent = {r_attr, r_off, r_hi, r_lo};

    // shared gap step: boundary, fit test
    logic          g_last;
    logic [PB-1:0] g_b, g_gap;
    logic          g_fit;
    assign g_last = (r_idx == r_count);
    assign g_b    = g_last ? r_user_high : ((e_s < r_user_high) ? e_s : r_user_high);
    assign g_gap  = g_b - r_cur;
    assign g_fit  = (g_b > r_cur) && (g_gap >= r_cnt);

    // request-time values
    logic [PB:0]   in_sum;
    logic [PB-1:0] un_end;
    assign in_sum = {1'b0, i_page} + {1'b0, i_page_count};
    assign un_end = in_sum[PB] ? PMAX : in_sum[PB-1:0];

    logic [PB:0] gap_sum;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;   n_page = r_page;  n_cnt = r_cnt;   n_down = r_down;
        n_attr   = r_attr;   n_off  = r_off;   n_lo  = r_lo;    n_hi   = r_hi;
        n_idx    = r_idx;    n_n    = r_n;     n_ins = r_ins;   n_cur  = r_cur;
        n_gok    = r_gok;    n_gfound = r_gfound;
        n_pa     = r_pa;     n_pb   = r_pb;    n_pa_v = r_pa_v; n_pb_v = r_pb_v;
        n_sel    = r_sel;    n_count = r_count;
        n_st     = r_st;     n_sp   = r_sp;    n_ep  = r_ep;    n_ro   = r_ro;
        n_ra     = r_ra;
        we       = 1'b0;
        wdata    = new_ent;
        gap_sum  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_mode;  n_page = i_page;  n_cnt = i_page_count;
                    n_down = i_search_downward;
                    n_attr = {i_shared_map, i_access_bits};
                    n_off  = i_page_offset;
                    n_st = ST_OK; n_sp = '0; n_ep = '0; n_ro = '0; n_ra = '0;
                    n_idx = '0; n_n = '0; n_ins = 1'b0; n_gok = 1'b0;
                    n_cur = r_user_low;
                    n_state = S_DONE;
                    case (i_mode)
                        MODE_LOOKUP: begin
                            n_st = ST_NOFIT;
                            if (r_count != '0) n_state = S_SRD;
                        end
                        MODE_FIND: begin
                            if (i_page_count == '0 || r_user_high <= r_user_low)
                                n_st = ST_NOFIT;
                            else
                                n_state = S_SRD;
                        end
                        MODE_MAP: begin
                            if (i_page_count == '0) begin
                                n_st = ST_NOFIT;
                            end else if (i_page == '0) begin
                                if (r_user_high <= r_user_low) n_st = ST_NOFIT;
                                else n_state = S_SRD;
                            end else if (i_page >= r_user_low &&
                                         in_sum <= {1'b0, r_user_high}) begin
                                n_lo = i_page;
                                n_hi = in_sum[PB-1:0];
                                n_state = (r_count == '0) ? S_FIN : S_CRD;
                            end else begin
                                n_st = ST_NOFIT;
                            end
                        end
                        default: begin
                            n_sp = i_page;
                            n_ep = un_end;
                            n_lo = i_page;
                            n_hi = un_end;
                            if (un_end > i_page)
                                n_state = (r_count == '0) ? S_FIN : S_CRD;
                        end
                    endcase
                end
            end

            S_SRD: n_state = S_SEV;

            S_SEV: begin
                if (r_mode == MODE_LOOKUP) begin
                    if (e_s <= r_page && r_page < e_e) begin
                        n_st = ST_OK; n_sp = e_s; n_ep = e_e; n_ro = e_o; n_ra = e_a;
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_state = (r_idx + CW'(1) == r_count) ? S_DONE : S_SRD;
                    end
                end else begin
                    // gap search step; a hit upward or the last boundary ends it
                    logic          fin;
                    logic          ok;
                    logic [PB-1:0] fs;
                    fin = 1'b0;
                    ok  = r_gok;
                    fs  = r_gfound;
                    if (g_fit) begin
                        if (!r_down) begin
                            fin = 1'b1; ok = 1'b1; fs = r_cur;
                        end else begin
                            ok = 1'b1; fs = g_b - r_cnt;
                        end
                    end
                    n_gok = ok;
                    n_gfound = fs;
                    if (g_last) fin = 1'b1;
                    if (e_e > r_cur) n_cur = e_e;
                    n_idx = r_idx + CW'(1);
                    if (fin) begin
                        gap_sum = {1'b0, fs} + {1'b0, r_cnt};
                        n_idx = '0;
                        if (!ok) begin
                            n_st = ST_NOFIT;
                            n_state = S_DONE;
                        end else if (r_mode == MODE_FIND) begin
                            n_sp = fs; n_ep = gap_sum[PB-1:0];
                            n_state = S_DONE;
                        end else begin
                            n_lo = fs; n_hi = gap_sum[PB-1:0];
                            n_state = (r_count == '0) ? S_FIN : S_CRD;
                        end
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end

            S_CRD: n_state = S_CEV;

            S_CEV: begin
                n_pa = cut_a; n_pa_v = cut_f.keep_a;
                n_pb = cut_b; n_pb_v = cut_f.keep_b;
                n_state = S_CWR;
            end

            S_CWR: begin
                if (r_pa_v) begin
                    we  = (r_n < NW'(ENTRIES));
                    n_n = r_n + NW'(1);
                    if (r_mode == MODE_MAP && !r_ins && pa_s > r_lo) begin
                        wdata = new_ent;
                        n_ins = 1'b1;
                    end else begin
                        wdata  = r_pa;
                        n_pa   = r_pb;
                        n_pa_v = r_pb_v;
                        n_pb_v = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                    n_state = (r_idx + CW'(1) == r_count) ? S_FIN : S_CRD;
                end
            end

            S_FIN: begin
                if (r_mode == MODE_MAP && !r_ins) begin
                    we    = (r_n < NW'(ENTRIES));
                    wdata = new_ent;
                    n_n   = r_n + NW'(1);
                    n_ins = 1'b1;
                end else begin
                    n_state = S_DONE;
                    if (r_n > NW'(ENTRIES)) begin
                        n_st = ST_FULL; n_sp = '0; n_ep = '0;
                    end else begin
                        n_sel   = ~r_sel;
                        n_count = r_n[CW-1:0];
                        if (r_mode == MODE_MAP) begin
                            n_sp = r_lo; n_ep = r_hi;
                        end
                    end
                end
            end

            S_DONE: begin
                if (!r_ov || !i_out_stall) n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= 1'b0;
            r_count     <= '0;
            r_ov        <= 1'b0;
            r_user_low  <= PB'(1024);
            r_user_high <= PB'(786432);
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_count <= n_count;
            if (r_state == S_DONE && (!r_ov || !i_out_stall))
                r_ov <= 1'b1;
            else if (!i_out_stall)
                r_ov <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LOW) r_user_low <= i_cfg_data;
                else                        r_user_high <= i_cfg_data;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;  r_page <= n_page;  r_cnt <= n_cnt;  r_down <= n_down;
        r_attr <= n_attr;  r_off  <= n_off;   r_lo  <= n_lo;   r_hi   <= n_hi;
        r_idx  <= n_idx;   r_n    <= n_n;     r_ins <= n_ins;  r_cur  <= n_cur;
        r_gok  <= n_gok;   r_gfound <= n_gfound;
        r_pa   <= n_pa;    r_pb   <= n_pb;    r_pa_v <= n_pa_v; r_pb_v <= n_pb_v;
        r_st   <= n_st;    r_sp   <= n_sp;    r_ep  <= n_ep;   r_ro   <= n_ro;
        r_ra   <= n_ra;
        if (r_state == S_DONE && (!r_ov || !i_out_stall)) begin
            r_o_st <= r_st; r_o_sp <= r_sp; r_o_ep <= r_ep;
            r_o_ro <= r_ro; r_o_ra <= r_ra;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_o_st;
    assign o_start_page    = r_o_sp;
    assign o_end_page      = r_o_ep;
    assign o_region_access = r_o_ra[2:0];
    assign o_region_shared = r_o_ra[3];
    assign o_region_offset = r_o_ro;
endmodule
`default_nettype wire

// ===== rtl/prt_bank.sv =====
// One bank of region entries, written once and read once per cycle.
`timescale 1ns / 1ps
`default_nettype none
module prt_bank
    import prt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int EW    = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [EW-1:0]            i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [EW-1:0]            o_rdata
);
    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/prt_cut.sv =====
// Trims, splits or drops one region against a half-open cut range.
`timescale 1ns / 1ps
`default_nettype none
module prt_cut
    import prt_pkg::*;
#(
    parameter int PB = 20
) (
    input  wire  [3*PB+ATTR_W-1:0] i_entry,
    input  wire  [PB-1:0]          i_lo,
    input  wire  [PB-1:0]          i_hi,
    output logic [3*PB+ATTR_W-1:0] o_a,
    output logic [3*PB+ATTR_W-1:0] o_b,
    output t_cut_flags             o_flags
);
    logic [PB-1:0]     s, e, o;
    logic [ATTR_W-1:0] a;
    logic [PB-1:0]     o_trim;

    assign {a, o, e, s} = i_entry;
    assign o_trim = o + (i_hi - s);

    always_comb begin
        o_a     = i_entry;
        o_b     = i_entry;
        o_flags = '{keep_a: 1'b1, keep_b: 1'b0};
        if (e <= i_lo || s >= i_hi) begin
            o_a = i_entry;
        end else if (s < i_lo && e > i_hi) begin
            o_a     = {a, o, i_lo, s};
            o_b     = {a, o_trim, e, i_hi};
            o_flags = '{keep_a: 1'b1, keep_b: 1'b1};
        end else if (s < i_lo) begin
            o_a = {a, o, i_lo, s};
        end else if (e > i_hi) begin
            o_a = {a, o_trim, e, i_hi};
        end else begin
            o_flags = '{keep_a: 1'b0, keep_b: 1'b0};
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the page region table: random and directed map, unmap, find, lookup.
`timescale 1ns / 1ps
`default_nettype none

// Predicts every result of the table and checks the results against it, oldest first.
class region_scoreboard;
    localparam int DEPTH = 16;
    localparam logic [19:0] PMAX = 20'hFFFFF;

    // current register values
    logic [19:0] low_pg, high_pg;
    // the region table as the block should hold it
    logic [19:0] rs[DEPTH], re[DEPTH], ro[DEPTH];
    logic [3:0]  ra[DEPTH];
    int          count;
    // scratch table built while cutting a range out
    logic [19:0] ws[DEPTH+2], we_[DEPTH+2], wo[DEPTH+2];
    logic [3:0]  wa[DEPTH+2];

    // expected results, oldest first
    logic [1:0]  q_st[$];
    logic [19:0] q_sp[$], q_ep[$], q_off[$];
    logic [2:0]  q_acc[$];
    logic        q_sh[$];
    int          errors;
    int          checked;

    function void clear_table();
        low_pg = 20'd1024;
        high_pg = 20'd786432;
        count = 0;
        errors = 0;
        checked = 0;
    endfunction

    function void write_reg(logic idx, logic [19:0] val);
        if (idx == prt_pkg::CFG_LOW) low_pg = val;
        else high_pg = val;
    endfunction

    function int cut(longint lo, longint hi);
        int n;
        longint s, e, o;
        logic [3:0] a;
        n = 0;
        for (int i = 0; i < count; i++) begin
            s = longint'(rs[i]); e = longint'(re[i]); o = longint'(ro[i]); a = ra[i];
            if (e <= lo || s >= hi) begin
            end else if (s < lo && e > hi) begin
                ws[n] = 20'(s); we_[n] = 20'(lo); wo[n] = 20'(o); wa[n] = a; n++;
                o = (o + (hi - s)) & longint'(PMAX);
                s = hi;
            end else if (s < lo) begin
                e = lo;
            end else if (e > hi) begin
                o = (o + (hi - s)) & longint'(PMAX);
                s = hi;
            end else begin
                continue;
            end
            ws[n] = 20'(s); we_[n] = 20'(e); wo[n] = 20'(o); wa[n] = a; n++;
        end
        return n;
    endfunction

    function void commit(int n);
        for (int i = 0; i < n; i++) begin
            rs[i] = ws[i]; re[i] = we_[i]; ro[i] = wo[i]; ra[i] = wa[i];
        end
        count = n;
    endfunction

    function bit gap_search(longint cnt, bit down, output longint found);
        longint lo, hi, cur, b;
        bit ok, last;
        lo = longint'(low_pg); hi = longint'(high_pg); cur = lo; ok = 0; found = 0;
        if (cnt == 0 || hi <= lo) return 0;
        for (int i = 0; i <= count; i++) begin
            last = (i == count);
            b = last ? hi : ((longint'(rs[i]) < hi) ? longint'(rs[i]) : hi);
            if (b > cur && b - cur >= cnt) begin
                if (!down) begin
                    found = cur;
                    return 1;
                end
                found = b - cnt;
                ok = 1;
            end
            if (last) break;
            if (longint'(re[i]) > cur) cur = longint'(re[i]);
        end
        return ok;
    endfunction

    // note one accepted request and queue its expected result
    function void note_request(logic [1:0] mode, logic [19:0] page, logic [19:0] cnt,
                               bit down, logic [2:0] acc, bit sh, logic [19:0] off);
        logic [1:0] st;
        longint sp, ep, s, e;
        logic [2:0] r_acc;
        bit r_sh, ok;
        logic [19:0] r_off;
        int n, pos;
        st = prt_pkg::ST_OK; sp = 0; ep = 0; r_acc = 0; r_sh = 0; r_off = 0;
        case (mode)
            prt_pkg::MODE_LOOKUP: begin
                st = prt_pkg::ST_NOFIT;
                for (int i = 0; i < count; i++) begin
                    if (rs[i] <= page && page < re[i]) begin
                        st = prt_pkg::ST_OK;
                        sp = longint'(rs[i]); ep = longint'(re[i]);
                        r_acc = ra[i][2:0]; r_sh = ra[i][3]; r_off = ro[i];
                        break;
                    end
                end
            end
            prt_pkg::MODE_FIND: begin
                if (gap_search(longint'(cnt), down, s)) begin
                    sp = s; ep = s + longint'(cnt);
                end else st = prt_pkg::ST_NOFIT;
            end
            prt_pkg::MODE_MAP: begin
                s = longint'(page);
                if (cnt == 0) ok = 0;
                else if (page == 0) ok = gap_search(longint'(cnt), down, s);
                else ok = (page >= low_pg) &&
                          (longint'(page) + longint'(cnt) <= longint'(high_pg));
                if (!ok) st = prt_pkg::ST_NOFIT;
                else begin
                    n = cut(s, s + longint'(cnt));
                    if (n + 1 > DEPTH) st = prt_pkg::ST_FULL;
                    else begin
                        pos = 0;
                        while (pos < n && longint'(ws[pos]) <= s) pos++;
                        for (int k = n; k > pos; k--) begin
                            ws[k] = ws[k-1]; we_[k] = we_[k-1];
                            wo[k] = wo[k-1]; wa[k] = wa[k-1];
                        end
                        ws[pos] = 20'(s); we_[pos] = 20'(s + longint'(cnt));
                        wo[pos] = off; wa[pos] = {sh, acc};
                        commit(n + 1);
                        sp = s; ep = s + longint'(cnt);
                    end
                end
            end
            default: begin
                e = longint'(page) + longint'(cnt);
                if (e > longint'(PMAX)) e = longint'(PMAX);
                if (e > longint'(page)) begin
                    n = cut(longint'(page), e);
                    if (n > DEPTH) st = prt_pkg::ST_FULL;
                    else commit(n);
                end
                if (st == prt_pkg::ST_OK) begin
                    sp = longint'(page); ep = e;
                end
            end
        endcase
        q_st.push_back(st); q_sp.push_back(sp[19:0]); q_ep.push_back(ep[19:0]);
        q_acc.push_back(r_acc); q_sh.push_back(r_sh); q_off.push_back(r_off);
    endfunction

    function void check_result(logic [1:0] st, logic [19:0] sp, logic [19:0] ep,
                               logic [2:0] acc, logic sh, logic [19:0] off);
        logic [1:0] x_st;
        logic [19:0] x_sp, x_ep, x_off;
        logic [2:0] x_acc;
        logic x_sh;
        if (q_st.size() == 0) begin
            $error("unexpected result transaction: status %0d start %0h", st, sp);
            errors++;
            return;
        end
        x_st = q_st.pop_front(); x_sp = q_sp.pop_front(); x_ep = q_ep.pop_front();
        x_acc = q_acc.pop_front(); x_sh = q_sh.pop_front(); x_off = q_off.pop_front();
        checked++;
        if (st !== x_st) begin
            $error("status: expected %0d, got %0d", x_st, st); errors++;
        end
        if (sp !== x_sp) begin
            $error("start_page: expected %0h, got %0h", x_sp, sp); errors++;
        end
        if (ep !== x_ep) begin
            $error("end_page: expected %0h, got %0h", x_ep, ep); errors++;
        end
        if (acc !== x_acc) begin
            $error("region_access: expected %0d, got %0d", x_acc, acc); errors++;
        end
        if (sh !== x_sh) begin
            $error("region_shared: expected %0d, got %0d", x_sh, sh); errors++;
        end
        if (off !== x_off) begin
            $error("region_offset: expected %0h, got %0h", x_off, off); errors++;
        end
    endfunction

    function int pending();
        return q_st.size();
    endfunction
endclass

module tb;
    import prt_pkg::*;

    localparam int WATCHDOG = 20000;   // quiet cycles before giving up
    localparam int N_RANDOM = 1920;

    logic        clk, rst_n;
    logic        cfg_we, cfg_index;
    logic [19:0] cfg_data;
    logic        in_valid, in_stall;
    logic [1:0]  mode;
    logic [19:0] page, page_count, page_offset;
    logic        search_down, shared_map;
    logic [2:0]  access_bits;
    logic        out_valid, out_stall;
    logic [1:0]  status;
    logic [19:0] start_page, end_page, region_offset;
    logic [2:0]  region_access;
    logic        region_shared;

    region_scoreboard sb;
    int  quiet_cycles;
    int  maps_done, unmaps_done, finds_done, lookups_done;
    bit  stall_quiet;   // a stretch with the result side never stalling

    page_region_table uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_page(page), .i_page_count(page_count),
        .i_search_downward(search_down), .i_access_bits(access_bits),
        .i_shared_map(shared_map), .i_page_offset(page_offset),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_start_page(start_page), .o_end_page(end_page),
        .o_region_access(region_access), .o_region_shared(region_shared),
        .o_region_offset(region_offset)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, sampled on the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, start_page, end_page, region_access,
                            region_shared, region_offset);
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int g;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_quiet) out_stall <= 1'b0;
            else begin
                g = gap_len();
                if (g != 0) begin
                    out_stall <= 1'b1;
                    repeat (g) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // the block waits forever, so the run ends on a long quiet stretch
    always @(posedge clk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request transaction; the payload holds until it is taken, and valid
    // drops at the start of the next gap or at the next drain
    task automatic send(logic [1:0] m, logic [19:0] pg, logic [19:0] cnt, bit dn,
                        logic [2:0] acc, bit sh, logic [19:0] off);
        int g;
        g = gap_len();
        if (g != 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m; page <= pg; page_count <= cnt; search_down <= dn;
        access_bits <= acc; shared_map <= sh; page_offset <= off;
        do @(posedge clk); while (in_stall);
        sb.note_request(m, pg, cnt, dn, acc, sh, off);
        case (m)
            MODE_LOOKUP: lookups_done++;
            MODE_FIND:   finds_done++;
            MODE_MAP:    maps_done++;
            default:     unmaps_done++;
        endcase
        @(negedge clk);
    endtask

    // wait for every outstanding result, then a margin for the last table pass
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [19:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random request biased towards the live user window so regions pile up
    task automatic random_request(logic [19:0] lo, logic [19:0] hi);
        logic [1:0] m;
        logic [19:0] pg, cnt;
        int r;
        r = $urandom_range(0, 99);
        m = (r < 35) ? MODE_MAP : (r < 55) ? MODE_UNMAP : (r < 75) ? MODE_FIND : MODE_LOOKUP;
        r = $urandom_range(0, 99);
        if (r < 70) cnt = 20'($urandom_range(1, 64));
        else if (r < 90) cnt = 20'($urandom_range(1, 4096));
        else if (r < 95) cnt = 20'($urandom());
        else cnt = (r < 97) ? 20'd0 : 20'hFFFFF;
        r = $urandom_range(0, 99);
        if (r < 15) pg = 20'd0;
        else if (r < 85 && hi > lo) pg = lo + 20'($urandom() % 32'(hi - lo));
        else pg = 20'($urandom());
        send(m, pg, cnt, 1'($urandom_range(0, 1)), 3'($urandom()),
             1'($urandom_range(0, 1)), 20'($urandom()));
    endtask

    initial begin
        sb = new();
        sb.clear_table();
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_LOW; cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_LOOKUP; page = '0; page_count = '0; search_down = 1'b0;
        access_bits = '0; shared_map = 1'b0; page_offset = '0;
        quiet_cycles = 0; stall_quiet = 1'b0;
        maps_done = 0; unmaps_done = 0; finds_done = 0; lookups_done = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, searches both ways, zero counts, bounds, split, full
        send(MODE_LOOKUP, 20'd5000, 20'd1, 0, 0, 0, 0);
        send(MODE_FIND, 20'd0, 20'd16, 0, 0, 0, 0);
        send(MODE_FIND, 20'd0, 20'd16, 1, 0, 0, 0);
        send(MODE_FIND, 20'd0, 20'd0, 0, 0, 0, 0);
        send(MODE_MAP, 20'd0, 20'd0, 0, 3'd7, 1, 20'hFFFFF);
        send(MODE_MAP, 20'd1023, 20'd4, 0, 3'd1, 0, 0);        // below the window
        send(MODE_MAP, 20'd786430, 20'd4, 0, 3'd1, 0, 0);      // past the top
        send(MODE_MAP, 20'd2000, 20'd100, 0, 3'd5, 1, 20'hFFFF0);
        send(MODE_LOOKUP, 20'd2099, 20'd1, 0, 0, 0, 0);
        send(MODE_LOOKUP, 20'd2100, 20'd1, 0, 0, 0, 0);        // half-open end
        send(MODE_UNMAP, 20'd2040, 20'd20, 0, 0, 0, 0);        // split, offset wraps
        send(MODE_LOOKUP, 20'd2070, 20'd1, 0, 0, 0, 0);
        send(MODE_UNMAP, 20'd100, 20'd0, 0, 0, 0, 0);          // zero count unmap
        send(MODE_UNMAP, 20'hFFFF0, 20'hFFFFF, 0, 0, 0, 0);    // saturating end
        send(MODE_MAP, 20'd2050, 20'd30, 0, 3'd2, 0, 20'd7);   // remap over overlap
        for (int i = 0; i < 15; i++)
            send(MODE_MAP, 20'd0, 20'd3, i[0], i[2:0], i[1], 20'(i));
        send(MODE_UNMAP, 20'd2060, 20'd2, 0, 0, 0, 0);         // split in a full table
        send(MODE_FIND, 20'd0, 20'hFFFFF, 1, 0, 0, 0);
        drain();

        // random phases with varied windows, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            logic [19:0] lo, hi;
            case (ph)
                0: begin lo = 20'd1024; hi = 20'd786432; end
                1: begin lo = 20'd0; hi = 20'hFFFFF; end
                2: begin lo = 20'd4000; hi = 20'd4300; end
                3: begin lo = 20'd5000; hi = 20'd5000; end           // empty window
                4: begin lo = 20'hFFFFF; hi = 20'd0; end             // inverted window
                default: begin lo = 20'd100; hi = 20'd900; end
            endcase
            write_cfg(CFG_LOW, lo);
            write_cfg(CFG_HIGH, hi);
            stall_quiet = (ph == 2);
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                random_request(lo, hi);
                // now and then wipe the window so the table refills
                if ($urandom_range(0, 199) == 0) send(MODE_UNMAP, 20'd0, 20'hFFFFF, 0, 0, 0, 0);
            end
            drain();
        end

        $display("covered %0d maps, %0d unmaps, %0d gap searches, %0d lookups",
                 maps_done, unmaps_done, finds_done, lookups_done);
        $display("across six window settings; %0d results checked", sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
